### hdl/mrd_pkg.sv
// Shared types and constants of the MQTT receive deframer.
`default_nettype none

package mrd_pkg;

  localparam int unsigned LenW      = 28;
  localparam int unsigned TopicW    = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [3:0] TypeConnack = 4'd2;
  localparam logic [3:0] TypePublish = 4'd3;

  localparam logic [2:0] RoleHeader    = 3'd0;
  localparam logic [2:0] RoleLength    = 3'd1;
  localparam logic [2:0] RoleTopicLen  = 3'd2;
  localparam logic [2:0] RoleTopic     = 3'd3;
  localparam logic [2:0] RolePayload   = 3'd4;
  localparam logic [2:0] RoleOtherBody = 3'd5;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [3:0]        packet_type;
    logic [2:0]        role;
    logic [LenW-1:0]   body_offset;
    logic [LenW-1:0]   body_length;
    logic [TopicW-1:0] topic_length;
    logic              packet_end;
    logic              length_error;
    logic              connack_ok;
  } front_item_t;

endpackage

`default_nettype wire

### hdl/mrd_parser.sv
// Front end: accepts stream bytes, tracks packet phase and labels each byte.
`default_nettype none

module mrd_parser #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                space_i,
  output logic                     in_ready_o,
  output logic                     push_o,
  output mrd_pkg::front_item_t     item_o
);

  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhLength = 2'd1;
  localparam logic [1:0] PhBody   = 2'd2;
  localparam logic [2:0] MaxBytes = 3'(MAX_LENGTH_BYTES);

  logic [1:0]                  phase_q, phase_d;
  logic [3:0]                  type_q, type_d;
  logic [1:0]                  qos_q, qos_d;
  logic [mrd_pkg::LenW-1:0]    len_q, len_d;
  logic [1:0]                  lcnt_q, lcnt_d;
  logic [mrd_pkg::LenW-1:0]    bcnt_q, bcnt_d;
  logic [mrd_pkg::TopicW-1:0]  topic_q, topic_d;
  logic                        ok_q, ok_d;

  logic                        accept;
  logic [mrd_pkg::LenW-1:0]    add_val;
  logic [mrd_pkg::LenW-1:0]    bnext;
  logic [mrd_pkg::LenW-1:0]    rel;
  logic [mrd_pkg::LenW-1:0]    past_topic;
  logic [mrd_pkg::LenW-1:0]    topic_ext;
  logic [7:0]                  b;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign push_o     = accept;
  assign b          = in_byte_i;

  assign add_val    = mrd_pkg::LenW'(b[6:0]) << (5'd7 * {3'd0, lcnt_q});
  assign bnext      = bcnt_q + 1'b1;
  assign topic_ext  = {{(mrd_pkg::LenW - mrd_pkg::TopicW){1'b0}}, topic_q};
  assign rel        = bcnt_q - mrd_pkg::LenW'(2);
  assign past_topic = rel - topic_ext;

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    qos_d   = qos_q;
    len_d   = len_q;
    lcnt_d  = lcnt_q;
    bcnt_d  = bcnt_q;
    topic_d = topic_q;
    ok_d    = ok_q;

    item_o              = '0;
    item_o.data_byte    = b;

    unique case (phase_q)
      PhHeader: begin
        type_d  = b[7:4];
        qos_d   = b[2:1];
        len_d   = '0;
        lcnt_d  = '0;
        bcnt_d  = '0;
        topic_d = '0;
        ok_d    = 1'b0;
        phase_d = PhLength;
        item_o.role = mrd_pkg::RoleHeader;
      end
      PhLength: begin
        len_d = len_q + add_val;
        item_o.role = mrd_pkg::RoleLength;
        if (!b[7]) begin
          if (len_d == '0) begin
            item_o.packet_end = 1'b1;
            phase_d = PhHeader;
          end else begin
            phase_d = PhBody;
          end
        end else if ({1'b0, lcnt_q} + 3'd1 >= MaxBytes) begin
          item_o.length_error = 1'b1;
          phase_d = PhHeader;
        end else begin
          lcnt_d = lcnt_q + 2'd1;
        end
      end
      PhBody: begin
        item_o.role = mrd_pkg::RoleOtherBody;
        if (type_q == mrd_pkg::TypePublish) begin
          if (bcnt_q == '0) begin
            topic_d = {b, 8'd0};
            item_o.role = mrd_pkg::RoleTopicLen;
          end else if (bcnt_q == mrd_pkg::LenW'(1)) begin
            topic_d = {topic_q[15:8], b};
            item_o.role = mrd_pkg::RoleTopicLen;
          end else if (rel < topic_ext) begin
            item_o.role = mrd_pkg::RoleTopic;
          end else if (qos_q != 2'd0 && past_topic < mrd_pkg::LenW'(2)) begin
            item_o.role = mrd_pkg::RoleOtherBody;
          end else begin
            item_o.role = mrd_pkg::RolePayload;
          end
        end else if (type_q == mrd_pkg::TypeConnack && bcnt_q == mrd_pkg::LenW'(1)) begin
          ok_d = (b == 8'd0);
        end
        item_o.body_offset = bcnt_q;
        bcnt_d = bnext;
        if (bnext >= len_q) begin
          item_o.packet_end = 1'b1;
          phase_d = PhHeader;
        end
      end
      default: begin
        phase_d = PhHeader;
      end
    endcase

    item_o.packet_type  = type_d;
    item_o.body_length  = len_d;
    item_o.topic_length = topic_d;
    item_o.connack_ok   = ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      type_q  <= '0;
      qos_q   <= '0;
      len_q   <= '0;
      lcnt_q  <= '0;
      bcnt_q  <= '0;
      topic_q <= '0;
      ok_q    <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      qos_q   <= qos_d;
      len_q   <= len_d;
      lcnt_q  <= lcnt_d;
      bcnt_q  <= bcnt_d;
      topic_q <= topic_d;
      ok_q    <= ok_d;
    end
  end

endmodule

`default_nettype wire

### hdl/mrd_queue.sv
// Short queue of labeled items between the parser and the output stage.
`default_nettype none

module mrd_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  mrd_pkg::front_item_t       push_item_i,
  output logic                       space_o,
  input  wire logic                  pop_i,
  output logic                       avail_o,
  output mrd_pkg::front_item_t       pop_item_o
);

  mrd_pkg::front_item_t mem_q [mrd_pkg::QueueDepth];

  logic [mrd_pkg::QueuePtrW-1:0] wptr_q, wptr_d;
  logic [mrd_pkg::QueuePtrW-1:0] rptr_q, rptr_d;
  logic [mrd_pkg::QueueCntW-1:0] cnt_q, cnt_d;
  logic                          do_pop;

  assign space_o    = cnt_q != mrd_pkg::QueueCntW'(mrd_pkg::QueueDepth);
  assign avail_o    = cnt_q != '0;
  assign pop_item_o = mem_q[rptr_q];
  assign do_pop     = pop_i && avail_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == mrd_pkg::QueuePtrW'(mrd_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == mrd_pkg::QueuePtrW'(mrd_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + mrd_pkg::QueueCntW'(push_i) - mrd_pkg::QueueCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hdl/mrd_out.sv
// Back end: forms the end-of-packet flags and holds the output item register.
`default_nettype none

module mrd_out (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               avail_i,
  input  mrd_pkg::front_item_t    item_i,
  output logic                    pop_o,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic [79:0]             m_tdata_o,
  output logic [9:0]              m_tuser_o,
  output logic                    m_tlast_o
);

  logic        vld_q;
  logic [79:0] data_q, data_d;
  logic [9:0]  user_q, user_d;
  logic        last_q;
  logic        acc_flag;
  logic        overrun_flag;
  logic [mrd_pkg::LenW-1:0] need;

  assign pop_o = avail_i && (!vld_q || m_tready_i);
  assign need  = mrd_pkg::LenW'(item_i.topic_length) + mrd_pkg::LenW'(2);

  always_comb begin
    acc_flag     = item_i.packet_end && item_i.packet_type == mrd_pkg::TypeConnack &&
                   item_i.body_length >= mrd_pkg::LenW'(2) && item_i.connack_ok;
    overrun_flag = item_i.packet_end && item_i.packet_type == mrd_pkg::TypePublish &&
                   need > item_i.body_length;
    data_d = {item_i.topic_length, item_i.body_length, item_i.body_offset, item_i.data_byte};
    user_d = {overrun_flag, acc_flag, item_i.length_error, item_i.role, item_i.packet_type};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (m_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= user_d;
      last_q <= item_i.packet_end;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = last_q;

endmodule

`default_nettype wire

### hdl/mqtt_rx_deframer_top.sv
// Top level of the MQTT receive deframer.
//
// The slave stream takes one received byte per item in s_axis_tdata. For every
// byte the master stream gives exactly one labeled item: the byte itself, its
// role, the packet type, the body offset and decoded remaining length, the
// topic length, and the end-of-packet flags. tlast marks the byte that
// completes a packet.
// An item is accepted every cycle while the downstream side keeps up; the
// parser labels each byte as it is taken and writes it into the queue, and
// the output register takes the labeled item from the queue.
// The parser stalls only when the two-entry queue is full, so a stalled
// receiver holds the output item and stops input after the queue fills.
// Reset empties the queue and output register and sets the parser to expect
// the first header byte of a packet.
// A length field whose last allowed byte still has its continuation bit set
// is reported in tuser, and the next byte is parsed as a new header byte.
`default_nettype none

module mqtt_rx_deframer_top #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] byte_out, [35:8] body_offset, [63:36] body_length, [79:64] topic_length
  output logic [79:0]      m_axis_tdata,
  // [3:0] packet_type, [6:4] role, [7] length_error, [8] connack_accepted,
  // [9] topic_overrun
  output logic [9:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  mrd_pkg::front_item_t push_item;
  mrd_pkg::front_item_t pop_item;
  logic                 push;
  logic                 space;
  logic                 avail;
  logic                 pop;

  mrd_parser #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .space_i    (space),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .item_o     (push_item)
  );

  mrd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .space_o     (space),
    .pop_i       (pop),
    .avail_o     (avail),
    .pop_item_o  (pop_item)
  );

  mrd_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (avail),
    .item_i     (pop_item),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
